// File: src/lttp_pkg.sv
package lttp_pkg;

	localparam int MAX_ZOOM = 30;
	localparam int COORD_FRAC_BITS = 22;

	localparam int LAT_W = 30;
	localparam int LON_W = 31;
	localparam int ZOOM_W = 5;
	localparam int TILE_W = 30;
	localparam int FRAC_W = 33;

	localparam int NITER = 40;
	localparam int IT_W = $clog2(NITER + 1);
	localparam int DW = 48;
	localparam int EXP_W = 7;
	localparam int POLAR_DEG = 86;

	// Longitude plus 180 degrees, then the quotient by 360 degrees in Q32.
	localparam int T_W = 34;
	localparam int U_SHIFT = 29 - COORD_FRAC_BITS;
	localparam int NUM_W = T_W - 1 + U_SHIFT;
	localparam int DIVISOR = 360 / 8;
	// The shifted longitude stays below 2^31, and 2^37 exceeds DIVISOR times that,
	// so a rounded-up reciprocal with this shift gives the exact quotient.
	localparam int U_RECIP_SHIFT = 37;

	localparam int MA_W = 48;
	localparam int MB_W = 64;
	localparam int MACC_W = MA_W + MB_W;
	localparam int TH_SHIFT = COORD_FRAC_BITS + 20;
	localparam int W_SHIFT = 48;

	typedef logic [63:0] u64_t;
	typedef u64_t tab_t [0:NITER];

	typedef struct packed {
		logic            go;
		logic [MA_W-1:0] a;
		logic [MB_W-1:0] b;
	} mac_req_t;

	// Constant evaluation only: shift and subtract long division.
	function automatic u64_t udiv(u64_t a, u64_t b);
		u64_t q;
		u64_t r;
		q = '0;
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[62:0], a[k]};
			if (r >= b) begin
				r = r - b;
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic u64_t q60_to_q40(u64_t v);
		return (v + (u64_t'(1) << 19)) >> 20;
	endfunction

	function automatic u64_t pow2_series(int i, bit alt);
		u64_t sum;
		u64_t term;
		int k;
		sum = '0;
		k = 0;
		while (60 - i * (2 * k + 1) >= 0) begin
			term = udiv(u64_t'(1) << (60 - i * (2 * k + 1)), u64_t'(2 * k + 1));
			if (alt && k[0])
				sum = sum - term;
			else
				sum = sum + term;
			k++;
		end
		return sum;
	endfunction

	function automatic u64_t recip_series(u64_t n, bit alt);
		u64_t p;
		u64_t sum;
		u64_t term;
		int k;
		p = udiv(u64_t'(1) << 60, n);
		sum = '0;
		k = 0;
		while (p != '0) begin
			term = udiv(p, u64_t'(2 * k + 1));
			if (alt && k[0])
				sum = sum - term;
			else
				sum = sum + term;
			p = udiv(p, n * n);
			k++;
		end
		return sum;
	endfunction

	function automatic u64_t quarter_pi();
		return (recip_series(u64_t'(5), 1'b1) << 2) - recip_series(u64_t'(239), 1'b1);
	endfunction

	function automatic tab_t make_atan();
		tab_t t;
		t[0] = q60_to_q40(quarter_pi());
		for (int i = 1; i <= NITER; i++)
			t[i] = q60_to_q40(pow2_series(i, 1'b1));
		return t;
	endfunction

	function automatic tab_t make_atanh();
		tab_t t;
		t[0] = '0;
		for (int i = 1; i <= NITER; i++)
			t[i] = q60_to_q40(pow2_series(i, 1'b0));
		return t;
	endfunction

	function automatic u64_t make_inv2pi();
		u64_t two_pi;
		u64_t rem;
		u64_t quo;
		two_pi = quarter_pi() << 3;
		rem = '0;
		quo = '0;
		for (int b = 100; b >= 0; b--) begin
			rem = (rem << 1) | u64_t'(b == 100);
			if (rem >= two_pi) begin
				rem = rem - two_pi;
				if (b < 64)
					quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	localparam tab_t ATAN_Q = make_atan();
	localparam tab_t ATANH_Q = make_atanh();
	localparam u64_t LN2_Q = q60_to_q40(recip_series(u64_t'(3), 1'b0) << 1);
	localparam u64_t HALFRAD_Q60 = udiv(quarter_pi(), u64_t'(90));
	localparam u64_t INV2PI_Q = make_inv2pi();
	localparam u64_t U_RECIP = udiv((u64_t'(1) << (U_RECIP_SHIFT + U_SHIFT))
		+ u64_t'(DIVISOR - 1), u64_t'(DIVISOR));

endpackage

// File: src/lttp_mac.sv
module lttp_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lttp_pkg::mac_req_t            req,
	output logic [lttp_pkg::MACC_W-1:0]   acc,
	output logic                          done
);
	import lttp_pkg::*;

	localparam int HALF_A = MA_W / 2;
	localparam int HALF_B = MB_W / 2;
	localparam int PP_W = HALF_A + HALF_B;

	logic [MA_W-1:0]   a_q;
	logic [MB_W-1:0]   b_q;
	logic [2:0]        idx_q;
	logic              busy_q;
	logic              pv_q;
	logic              done_q;
	logic [1:0]        psel_q;
	logic [PP_W-1:0]   pp_q;
	logic [MACC_W-1:0] acc_q;
	logic [HALF_A-1:0] a_part;
	logic [HALF_B-1:0] b_part;
	logic [MACC_W-1:0] pp_ext;

	// Four partial products, one per cycle; each is added in the cycle after it is formed.
	always_comb begin
		a_part = idx_q[1] ? a_q[MA_W-1:HALF_A] : a_q[HALF_A-1:0];
		b_part = idx_q[0] ? b_q[MB_W-1:HALF_B] : b_q[HALF_B-1:0];
		pp_ext = MACC_W'(pp_q) << ((psel_q[1] ? HALF_A : 0) + (psel_q[0] ? HALF_B : 0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pv_q   <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				pv_q   <= 1'b0;
				idx_q  <= '0;
			end else if (busy_q) begin
				pv_q <= !idx_q[2];
				if (!idx_q[2]) begin
					idx_q <= idx_q + 3'd1;
				end else if (pv_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (!idx_q[2]) begin
				pp_q   <= a_part * b_part;
				psel_q <= idx_q[1:0];
			end
			if (pv_q)
				acc_q <= acc_q + pp_ext;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// File: src/lttp_div.sv
module lttp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lttp_pkg::NUM_W-1:0]  num,
	output logic [lttp_pkg::NUM_W-1:0]  quot,
	output logic                        done
);
	import lttp_pkg::*;

	mac_req_t          mac_req;
	logic [MACC_W-1:0] mac_acc;
	logic              mac_done;

	lttp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	// The low numerator bits are zero, so the shifted longitude times the rounded-up
	// reciprocal of the divisor gives the quotient after a fixed right shift.
	always_comb begin
		mac_req.go = start;
		mac_req.a  = MA_W'(num[NUM_W-1:U_SHIFT]);
		mac_req.b  = U_RECIP;
	end

	assign quot = mac_acc[U_RECIP_SHIFT +: NUM_W];
	assign done = mac_done;

endmodule

// File: src/lttp_engine.sv
module lttp_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [lttp_pkg::LAT_W-1:0]  latitude,
	output logic [lttp_pkg::FRAC_W-1:0]        v_frac,
	output logic                               done
);
	import lttp_pkg::*;

	typedef enum logic [7:0] {
		E_IDLE  = 8'b0000_0001,
		E_THETA = 8'b0000_0010,
		E_CIRC  = 8'b0000_0100,
		E_FORM  = 8'b0000_1000,
		E_NORM  = 8'b0001_0000,
		E_HYP   = 8'b0010_0000,
		E_LN    = 8'b0100_0000,
		E_SCALE = 8'b1000_0000
	} eng_state_t;

	localparam logic signed [31:0]   LAT_LIM = 32'(POLAR_DEG * (2 ** COORD_FRAC_BITS));
	localparam logic signed [DW-1:0] ONE = DW'(1);
	localparam logic signed [DW-1:0] ONE40 = DW'(64'd1 << 40);
	localparam logic signed [DW-1:0] TWO41 = DW'(64'd1 << 41);
	localparam logic signed [DW-1:0] HALF31 = DW'(64'd1 << 31);
	localparam logic signed [DW-1:0] TOP32 = DW'(64'd1 << 32);
	localparam logic [IT_W-1:0]      REP_A = IT_W'(4);
	localparam logic [IT_W-1:0]      REP_B = IT_W'(13);
	localparam logic [IT_W-1:0]      IT_LAST = IT_W'(NITER);

	eng_state_t              state_q;
	logic signed [DW-1:0]    x_q;
	logic signed [DW-1:0]    y_q;
	logic signed [DW-1:0]    z_q;
	logic [IT_W-1:0]         it_q;
	logic                    rep_q;
	logic                    neg_q;
	logic                    dneg_q;
	logic signed [EXP_W-1:0] ep_q;
	logic signed [EXP_W-1:0] eq_q;
	logic                    go_q;
	logic [MA_W-1:0]         mac_a_q;
	logic [MB_W-1:0]         mac_b_q;
	logic [FRAC_W-1:0]       v_q;
	logic                    done_q;

	mac_req_t                mac_req;
	logic [MACC_W-1:0]       mac_acc;
	logic                    mac_done;

	logic signed [31:0]      lat_ext;
	logic signed [31:0]      lat_c;
	logic [31:0]             lat_mag;
	logic                    hyp;
	logic signed [DW-1:0]    dx;
	logic signed [DW-1:0]    dy;
	logic signed [DW-1:0]    ang;
	logic                    zpos;
	logic                    ypos;
	logic                    xsub;
	logic                    ysub;
	logic                    zsub;
	logic signed [DW-1:0]    x_nx;
	logic signed [DW-1:0]    y_nx;
	logic signed [DW-1:0]    z_nx;
	logic                    circ_last;
	logic                    rep_it;
	logic                    hyp_last;
	logic signed [DW-1:0]    p_sum;
	logic signed [DW-1:0]    q_dif;
	logic                    x_hi;
	logic                    x_lo;
	logic                    y_hi;
	logic                    y_lo;
	logic                    normed;
	logic signed [DW-1:0]    th;
	logic signed [EXP_W-1:0] d_exp;
	logic [EXP_W-1:0]        d_abs;
	logic signed [DW-1:0]    ln_part;
	logic signed [DW-1:0]    a_val;
	logic [DW-1:0]           a_abs;
	logic signed [DW-1:0]    w_val;
	logic signed [DW-1:0]    v_raw;

	lttp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	always_comb begin
		mac_req.go = go_q;
		mac_req.a  = mac_a_q;
		mac_req.b  = mac_b_q;

		lat_ext = 32'(latitude);
		if (lat_ext > LAT_LIM)
			lat_c = LAT_LIM;
		else if (lat_ext < -LAT_LIM)
			lat_c = -LAT_LIM;
		else
			lat_c = lat_ext;
		lat_mag = lat_c[31] ? 32'(-lat_c) : 32'(lat_c);

		// One shift-add unit serves both the circular and the hyperbolic passes.
		hyp  = state_q == E_HYP;
		dx   = y_q >>> it_q;
		dy   = x_q >>> it_q;
		ang  = hyp ? $signed(ATANH_Q[it_q][DW-1:0]) : $signed(ATAN_Q[it_q][DW-1:0]);
		zpos = !z_q[DW-1];
		ypos = !y_q[DW-1] && (y_q != '0);
		xsub = hyp ? ypos : zpos;
		ysub = hyp ? ypos : !zpos;
		zsub = hyp ? !ypos : zpos;
		x_nx = xsub ? x_q - dx : x_q + dx;
		y_nx = ysub ? y_q - dy : y_q + dy;
		z_nx = zsub ? z_q - ang : z_q + ang;

		circ_last = it_q == IT_LAST;
		// The hyperbolic pass repeats some iterations so that it converges.
		rep_it   = (it_q == REP_A) || (it_q == REP_B) || (it_q == IT_LAST);
		hyp_last = (it_q == IT_LAST) && rep_q;

		p_sum = x_q + y_q;
		q_dif = x_q - y_q;

		x_hi   = x_q >= TWO41;
		x_lo   = x_q < ONE40;
		y_hi   = y_q >= TWO41;
		y_lo   = y_q < ONE40;
		normed = !x_hi && !x_lo && !y_hi && !y_lo;

		th      = $signed(mac_acc[TH_SHIFT +: DW]);
		d_exp   = ep_q - eq_q;
		d_abs   = d_exp[EXP_W-1] ? EXP_W'(-d_exp) : EXP_W'(d_exp);
		ln_part = $signed(mac_acc[DW-1:0]);
		a_val   = (dneg_q ? -ln_part : ln_part) + (z_q <<< 1);
		a_abs   = a_val[DW-1] ? DW'(-a_val) : DW'(a_val);
		w_val   = $signed(mac_acc[W_SHIFT +: DW]);
		v_raw   = z_q[DW-1] ? HALF31 + w_val : HALF31 - w_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			it_q    <= '0;
			rep_q   <= 1'b0;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						go_q    <= 1'b1;
						state_q <= E_THETA;
					end
				end
				E_THETA: begin
					if (mac_done) begin
						it_q    <= '0;
						state_q <= E_CIRC;
					end
				end
				E_CIRC: begin
					if (circ_last)
						state_q <= E_FORM;
					else
						it_q <= it_q + IT_W'(1);
				end
				E_FORM: begin
					state_q <= E_NORM;
				end
				E_NORM: begin
					if (normed) begin
						it_q    <= IT_W'(1);
						rep_q   <= 1'b0;
						state_q <= E_HYP;
					end
				end
				E_HYP: begin
					if (hyp_last) begin
						go_q    <= 1'b1;
						state_q <= E_LN;
					end else if (rep_it && !rep_q) begin
						rep_q <= 1'b1;
					end else begin
						rep_q <= 1'b0;
						it_q  <= it_q + IT_W'(1);
					end
				end
				E_LN: begin
					if (mac_done) begin
						go_q    <= 1'b1;
						state_q <= E_SCALE;
					end
				end
				E_SCALE: begin
					if (mac_done) begin
						done_q  <= 1'b1;
						state_q <= E_IDLE;
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			E_IDLE: begin
				if (start) begin
					mac_a_q <= MA_W'(lat_mag);
					mac_b_q <= HALFRAD_Q60;
					neg_q   <= lat_c[31];
				end
			end
			E_THETA: begin
				if (mac_done) begin
					z_q <= neg_q ? -th : th;
					x_q <= ONE40;
					y_q <= '0;
				end
			end
			E_CIRC: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= z_nx;
			end
			E_FORM: begin
				x_q  <= (p_sum < ONE) ? ONE : p_sum;
				y_q  <= (q_dif < ONE) ? ONE : q_dif;
				ep_q <= '0;
				eq_q <= '0;
			end
			E_NORM: begin
				if (normed) begin
					x_q <= p_sum;
					y_q <= q_dif;
					z_q <= '0;
				end else begin
					if (x_hi) begin
						x_q  <= x_q >>> 1;
						ep_q <= ep_q + EXP_W'(1);
					end else if (x_lo) begin
						x_q  <= x_q <<< 1;
						ep_q <= ep_q - EXP_W'(1);
					end
					if (y_hi) begin
						y_q  <= y_q >>> 1;
						eq_q <= eq_q + EXP_W'(1);
					end else if (y_lo) begin
						y_q  <= y_q <<< 1;
						eq_q <= eq_q - EXP_W'(1);
					end
				end
			end
			E_HYP: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= z_nx;
				if (hyp_last) begin
					mac_a_q <= MA_W'(d_abs);
					mac_b_q <= LN2_Q;
					dneg_q  <= d_exp[EXP_W-1];
				end
			end
			E_LN: begin
				if (mac_done) begin
					z_q     <= a_val;
					mac_a_q <= MA_W'(a_abs);
					mac_b_q <= INV2PI_Q;
				end
			end
			E_SCALE: begin
				if (mac_done) begin
					if (v_raw[DW-1])
						v_q <= '0;
					else if (v_raw > TOP32)
						v_q <= FRAC_W'(TOP32);
					else
						v_q <= FRAC_W'(v_raw);
				end
			end
			default: begin
			end
		endcase
	end

	assign v_frac = v_q;
	assign done   = done_q;

endmodule

// File: src/latlon_to_tile_pyramid_top.sv
// Channel   Handshake             Payload
// input     in_valid / in_ready   latitude, longitude, deepest_zoom
// output    out_valid / out_ready tile_column, tile_row, tile_zoom, final_result
//
// A point's computation time is set by the CORDIC engine: three multiplies on a
// shared 24x32 unit, 41 circular and 43 hyperbolic iterations of one shift-add unit,
// and a normalization of one bit per cycle (up to four shifts) plus setup and handoff.
// The longitude quotient, a reciprocal multiply, runs alongside it. Then one result
// leaves per cycle, zoom 0 up to the deepest zoom (capped at MAX_ZOOM), slowed only
// by out_ready. in_ready is low from acceptance until the last result is loaded into
// the output register. Reset is asynchronous, active low.
module latlon_to_tile_pyramid_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [lttp_pkg::LAT_W-1:0]  latitude,
	input  logic signed [lttp_pkg::LON_W-1:0]  longitude,
	input  logic [lttp_pkg::ZOOM_W-1:0]        deepest_zoom,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [lttp_pkg::TILE_W-1:0]        tile_column,
	output logic [lttp_pkg::TILE_W-1:0]        tile_row,
	output logic [lttp_pkg::ZOOM_W-1:0]        tile_zoom,
	output logic                               final_result
);
	import lttp_pkg::*;

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_CALC = 3'b010,
		T_EMIT = 3'b100
	} top_state_t;

	localparam logic signed [T_W-1:0] LON_BIAS = T_W'(180) << COORD_FRAC_BITS;
	localparam logic [NUM_W-1:0]      U_MAX = NUM_W'(64'd1 << 32);

	top_state_t          state_q;
	logic                u_rdy_q;
	logic                v_rdy_q;
	logic [ZOOM_W-1:0]   zc_q;
	logic [ZOOM_W-1:0]   limit_q;
	logic [FRAC_W-1:0]   u_q;
	logic                out_valid_q;
	logic [TILE_W-1:0]   col_q;
	logic [TILE_W-1:0]   row_q;
	logic [ZOOM_W-1:0]   zoom_q;
	logic                final_q;

	logic                accept;
	logic                load;
	logic                last;
	logic signed [T_W-1:0] lon_t;
	logic [NUM_W-1:0]    num;
	logic [NUM_W-1:0]    quot;
	logic                div_done;
	logic [FRAC_W-1:0]   v_frac;
	logic                eng_done;
	logic [5:0]          sh;
	logic [FRAC_W-1:0]   top_v;
	logic [FRAC_W-1:0]   col_full;
	logic [FRAC_W-1:0]   row_full;

	lttp_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.latitude (latitude),
		.v_frac   (v_frac),
		.done     (eng_done)
	);

	lttp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.num    (num),
		.quot   (quot),
		.done   (div_done)
	);

	always_comb begin
		in_ready = state_q == T_IDLE;
		accept   = in_valid && in_ready;
		load     = (state_q == T_EMIT) && (!out_valid_q || out_ready);
		last     = zc_q == limit_q;

		lon_t = T_W'(longitude) + LON_BIAS;
		num   = (!lon_t[T_W-1] && (lon_t != '0)) ? {lon_t[T_W-2:0], U_SHIFT'(0)} : '0;

		sh       = 6'd32 - {1'b0, zc_q};
		top_v    = (FRAC_W'(1) << zc_q) - FRAC_W'(1);
		col_full = u_q >> sh;
		row_full = v_frac >> sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			u_rdy_q     <= 1'b0;
			v_rdy_q     <= 1'b0;
			zc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						u_rdy_q <= 1'b0;
						v_rdy_q <= 1'b0;
						state_q <= T_CALC;
					end
				end
				T_CALC: begin
					if (div_done)
						u_rdy_q <= 1'b1;
					if (eng_done)
						v_rdy_q <= 1'b1;
					if ((u_rdy_q || div_done) && (v_rdy_q || eng_done)) begin
						zc_q    <= '0;
						state_q <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (load) begin
						zc_q <= zc_q + ZOOM_W'(1);
						if (last)
							state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			limit_q <= (deepest_zoom > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : deepest_zoom;
		if (div_done)
			u_q <= (quot > U_MAX) ? FRAC_W'(U_MAX) : quot[FRAC_W-1:0];
		if (load) begin
			col_q   <= (col_full > top_v) ? top_v[TILE_W-1:0] : col_full[TILE_W-1:0];
			row_q   <= (row_full > top_v) ? top_v[TILE_W-1:0] : row_full[TILE_W-1:0];
			zoom_q  <= zc_q;
			final_q <= last;
		end
	end

	assign out_valid    = out_valid_q;
	assign tile_column  = col_q;
	assign tile_row     = row_q;
	assign tile_zoom    = zoom_q;
	assign final_result = final_q;

endmodule

// File: src/lttp_checker.sv
module lttp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [lttp_pkg::TILE_W-1:0]  tile_column,
	input logic [lttp_pkg::TILE_W-1:0]  tile_row,
	input logic [lttp_pkg::ZOOM_W-1:0]  tile_zoom,
	input logic                         final_result
);
	import lttp_pkg::*;

	// The block works on one point at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a point is still in progress");

	// Tile indexes stay inside the grid of their zoom level.
	a_tile_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((tile_column >> tile_zoom) == '0) && ((tile_row >> tile_zoom) == '0))
		else $error("tile index outside the grid of its zoom level");

	// Zoom levels of one point count up by one.
	a_zoom_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !final_result |=>
		!out_valid || (tile_zoom == ZOOM_W'($past(tile_zoom) + ZOOM_W'(1))))
		else $error("zoom level did not advance by one");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tile_column) && $stable(tile_row)
		&& $stable(tile_zoom) && $stable(final_result))
		else $error("stalled output transaction changed");

endmodule

bind latlon_to_tile_pyramid_top lttp_checker u_lttp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.tile_column  (tile_column),
	.tile_row     (tile_row),
	.tile_zoom    (tile_zoom),
	.final_result (final_result)
);
